/* rtl/core/sews_pkg.sv */
// Shared types, codes and defaults of the sliding event window store.
`default_nettype none
package sews_pkg;

  localparam int DEF_WINDOW_DEPTH      = 64;
  localparam int DEF_FIXED_VALUE_BYTES = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RETENTION_TIME   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_EVENT_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TOTAL_BYTES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOWED_LATENESS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LATE_POLICY      = 3'd4;

  // Late event policies.
  localparam logic [1:0] LATE_DROP   = 2'd0;
  localparam logic [1:0] LATE_ACCEPT = 2'd1;
  localparam logic [1:0] LATE_ERROR  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INVALID    = 2'd1;
  localparam logic [1:0] ST_LATE_DROP  = 2'd2;
  localparam logic [1:0] ST_LATE_ERROR = 2'd3;

  typedef struct packed {
    logic [63:0] time_ms;
    logic [31:0] tag;
    logic [16:0] bytes;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   item;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_INSERT,
    S_CUTOFF,
    S_RETAIN,
    S_COUNT,
    S_BYTES,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

/* rtl/core/sews_cell.sv */
// One slot of the window chain: holds an entry, inserts in order or shifts toward the head.
`default_nettype none
module sews_cell #(
  parameter int WINDOW_DEPTH = sews_pkg::DEF_WINDOW_DEPTH,
  parameter int IDX          = 0,
  localparam int CNT_W       = $clog2(WINDOW_DEPTH + 2)
) (
  input  wire                 clk,
  input  wire [CNT_W-1:0]     total,
  input  sews_pkg::cell_cmd_t cmd,
  input  sews_pkg::entry_t    left_entry,
  input  wire                 left_gt,
  input  sews_pkg::entry_t    right_entry,
  output sews_pkg::entry_t    entry,
  output logic                gt
);

  sews_pkg::entry_t entry_r;
  sews_pkg::entry_t entry_nxt;
  logic             occupied;
  logic             at_end;

  assign occupied = CNT_W'(IDX) < total;
  assign at_end   = total == CNT_W'(IDX);
  assign gt       = occupied && (entry_r.time_ms > cmd.item.time_ms);
  assign entry    = entry_r;

  // The chain is sorted, so the left neighbor being later than the new time
  // means everything from here on moves up by one slot.
  always_comb begin
    entry_nxt = entry_r;
    unique case (cmd.op)
      sews_pkg::CELL_HOLD:   entry_nxt = entry_r;
      sews_pkg::CELL_INSERT: begin
        if (left_gt) begin
          entry_nxt = left_entry;
        end else if (gt || at_end) begin
          entry_nxt = cmd.item;
        end
      end
      sews_pkg::CELL_SHIFT:  entry_nxt = right_entry;
      default:               entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
`default_nettype wire

/* rtl/core/sews_ctrl.sv */
// Sequencer of the window store: late check, insertion, eviction passes and result register.
`default_nettype none
module sews_ctrl #(
  parameter int WINDOW_DEPTH      = sews_pkg::DEF_WINDOW_DEPTH,
  parameter int FIXED_VALUE_BYTES = sews_pkg::DEF_FIXED_VALUE_BYTES,
  localparam int CNT_W            = $clog2(WINDOW_DEPTH + 2)
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_we,
  input  wire [sews_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [sews_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire [63:0]                     in_event_time,
  input  wire [31:0]                     in_event_tag,
  input  wire [15:0]                     in_name_length,
  input  wire                            in_value_is_text,
  input  wire [15:0]                     in_text_length,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [1:0]                     out_status,
  output logic                           out_stored,
  output logic [6:0]                     out_held_count,
  output logic [63:0]                    out_current_watermark,
  output logic [23:0]                    out_held_bytes,
  output logic [6:0]                     out_evicted_count,
  input  sews_pkg::entry_t               head_entry,
  output sews_pkg::cell_cmd_t            cell_cmd,
  output logic [CNT_W-1:0]               total
);

  sews_pkg::state_t state_r, state_nxt;

  logic [31:0] retention_r,  retention_nxt;
  logic [6:0]  max_count_r,  max_count_nxt;
  logic [23:0] max_bytes_r,  max_bytes_nxt;
  logic [31:0] lateness_r,   lateness_nxt;
  logic [1:0]  policy_r,     policy_nxt;

  sews_pkg::entry_t item_r, item_nxt;
  logic             name_zero_r, name_zero_nxt;

  logic [CNT_W-1:0] total_r,     total_nxt;
  logic [23:0]      byte_total_r, byte_total_nxt;
  logic [63:0]      wm_r,        wm_nxt;
  logic [63:0]      cutoff_r,    cutoff_nxt;
  logic [CNT_W-1:0] evicted_r,   evicted_nxt;
  logic [1:0]       status_r,    status_nxt;
  logic             stored_r,    stored_nxt;

  logic        out_valid_r,  out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic        out_stored_r, out_stored_nxt;
  logic [6:0]  out_count_r,  out_count_nxt;
  logic [63:0] out_wm_r,     out_wm_nxt;
  logic [23:0] out_bytes_r,  out_bytes_nxt;
  logic [6:0]  out_evict_r,  out_evict_nxt;

  logic             accept;
  logic             late;
  logic             reject;
  logic [CNT_W-1:0] limit;
  logic             retain_hit;
  logic             count_hit;
  logic             bytes_hit;
  logic             evict;
  logic             load_out;
  logic [16:0]      cost;

  assign accept = in_valid && !in_stall;
  assign late   = (item_r.time_ms < wm_r) &&
                  ((wm_r - item_r.time_ms) > {32'd0, lateness_r});
  assign reject = name_zero_r || late;
  assign limit  = (32'(max_count_r) > 32'(WINDOW_DEPTH)) ? CNT_W'(WINDOW_DEPTH)
                                                         : CNT_W'(max_count_r);
  assign retain_hit = (total_r != '0) && (head_entry.time_ms < cutoff_r);
  assign count_hit  = total_r > limit;
  assign bytes_hit  = (total_r != '0) && (byte_total_r > max_bytes_r);
  assign cost = 17'(in_name_length) +
                (in_value_is_text ? 17'(in_text_length) : 17'(FIXED_VALUE_BYTES));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sews_pkg::S_IDLE:   if (accept) state_nxt = sews_pkg::S_CHECK;
      sews_pkg::S_CHECK:  state_nxt = reject ? sews_pkg::S_DONE : sews_pkg::S_INSERT;
      sews_pkg::S_INSERT: state_nxt = sews_pkg::S_CUTOFF;
      sews_pkg::S_CUTOFF: state_nxt = sews_pkg::S_RETAIN;
      sews_pkg::S_RETAIN: if (!retain_hit) state_nxt = sews_pkg::S_COUNT;
      sews_pkg::S_COUNT:  if (!count_hit) state_nxt = sews_pkg::S_BYTES;
      sews_pkg::S_BYTES:  if (!bytes_hit) state_nxt = sews_pkg::S_DONE;
      sews_pkg::S_DONE:   if (load_out) state_nxt = sews_pkg::S_IDLE;
      default:            state_nxt = sews_pkg::S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall      = state_r != sews_pkg::S_IDLE;
    evict         = ((state_r == sews_pkg::S_RETAIN) && retain_hit) ||
                    ((state_r == sews_pkg::S_COUNT)  && count_hit)  ||
                    ((state_r == sews_pkg::S_BYTES)  && bytes_hit);
    load_out      = (state_r == sews_pkg::S_DONE) && (!out_valid_r || !out_stall);
    cell_cmd.item = item_r;
    if (state_r == sews_pkg::S_INSERT) begin
      cell_cmd.op = sews_pkg::CELL_INSERT;
    end else if (evict) begin
      cell_cmd.op = sews_pkg::CELL_SHIFT;
    end else begin
      cell_cmd.op = sews_pkg::CELL_HOLD;
    end
  end

  // Configuration registers.
  always_comb begin
    retention_nxt = retention_r;
    max_count_nxt = max_count_r;
    max_bytes_nxt = max_bytes_r;
    lateness_nxt  = lateness_r;
    policy_nxt    = policy_r;
    if (cfg_we) begin
      unique case (cfg_index)
        sews_pkg::REG_RETENTION_TIME:   retention_nxt = cfg_wdata;
        sews_pkg::REG_MAX_EVENT_COUNT:  max_count_nxt = cfg_wdata[6:0];
        sews_pkg::REG_MAX_TOTAL_BYTES:  max_bytes_nxt = cfg_wdata[23:0];
        sews_pkg::REG_ALLOWED_LATENESS: lateness_nxt  = cfg_wdata;
        sews_pkg::REG_LATE_POLICY:      policy_nxt    = cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Window bookkeeping.
  always_comb begin
    item_nxt       = item_r;
    name_zero_nxt  = name_zero_r;
    total_nxt      = total_r;
    byte_total_nxt = byte_total_r;
    wm_nxt         = wm_r;
    cutoff_nxt     = cutoff_r;
    evicted_nxt    = evicted_r;
    status_nxt     = status_r;
    stored_nxt     = stored_r;

    if (accept) begin
      item_nxt.time_ms = in_event_time;
      item_nxt.tag     = in_event_tag;
      item_nxt.bytes   = cost;
      name_zero_nxt    = in_name_length == 16'd0;
    end

    if (state_r == sews_pkg::S_CHECK) begin
      evicted_nxt = '0;
      stored_nxt  = !reject;
      if (name_zero_r) begin
        status_nxt = sews_pkg::ST_INVALID;
      end else if (late) begin
        if (policy_r == sews_pkg::LATE_DROP) begin
          status_nxt = sews_pkg::ST_LATE_DROP;
        end else if (policy_r == sews_pkg::LATE_ERROR) begin
          status_nxt = sews_pkg::ST_LATE_ERROR;
        end else begin
          status_nxt = sews_pkg::ST_OK;
        end
      end else begin
        status_nxt = sews_pkg::ST_OK;
      end
    end

    if (state_r == sews_pkg::S_INSERT) begin
      total_nxt      = total_r + CNT_W'(1);
      byte_total_nxt = byte_total_r + 24'(item_r.bytes);
      if (item_r.time_ms > wm_r) begin
        wm_nxt = item_r.time_ms;
      end
    end

    if (state_r == sews_pkg::S_CUTOFF) begin
      cutoff_nxt = (wm_r > {32'd0, retention_r}) ? wm_r - {32'd0, retention_r} : 64'd0;
    end

    if (evict) begin
      total_nxt      = total_r - CNT_W'(1);
      byte_total_nxt = byte_total_r - 24'(head_entry.bytes);
      evicted_nxt    = evicted_r + CNT_W'(1);
    end
  end

  // Result register; it frees the sequencer while the result waits.
  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_stored_nxt = out_stored_r;
    out_count_nxt  = out_count_r;
    out_wm_nxt     = out_wm_r;
    out_bytes_nxt  = out_bytes_r;
    out_evict_nxt  = out_evict_r;
    if (load_out) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_r;
      out_stored_nxt = stored_r;
      out_count_nxt  = 7'(total_r);
      out_wm_nxt     = wm_r;
      out_bytes_nxt  = byte_total_r;
      out_evict_nxt  = 7'(evicted_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sews_pkg::S_IDLE;
      retention_r  <= 32'd1000;
      max_count_r  <= 7'd64;
      max_bytes_r  <= 24'hFFFFFF;
      lateness_r   <= 32'd0;
      policy_r     <= sews_pkg::LATE_DROP;
      total_r      <= '0;
      byte_total_r <= 24'd0;
      wm_r         <= 64'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      retention_r  <= retention_nxt;
      max_count_r  <= max_count_nxt;
      max_bytes_r  <= max_bytes_nxt;
      lateness_r   <= lateness_nxt;
      policy_r     <= policy_nxt;
      total_r      <= total_nxt;
      byte_total_r <= byte_total_nxt;
      wm_r         <= wm_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    name_zero_r  <= name_zero_nxt;
    cutoff_r     <= cutoff_nxt;
    evicted_r    <= evicted_nxt;
    status_r     <= status_nxt;
    stored_r     <= stored_nxt;
    out_status_r <= out_status_nxt;
    out_stored_r <= out_stored_nxt;
    out_count_r  <= out_count_nxt;
    out_wm_r     <= out_wm_nxt;
    out_bytes_r  <= out_bytes_nxt;
    out_evict_r  <= out_evict_nxt;
  end

  assign total                 = total_r;
  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_stored            = out_stored_r;
  assign out_held_count        = out_count_r;
  assign out_current_watermark = out_wm_r;
  assign out_held_bytes        = out_bytes_r;
  assign out_evicted_count     = out_evict_r;

endmodule
`default_nettype wire

/* rtl/core/sliding_event_window_store.sv */
// Top level of the sliding event window store: sequencer plus the chain of entry cells.
`default_nettype none
// Keeps timestamped events sorted in a chain of WINDOW_DEPTH+1 cells and evicts
// from the oldest end by retention time, event count and byte budget. One request
// is worked on at a time: a rejected request (zero name length or too late) goes
// from the late check straight to the result register; a stored one is inserted,
// gets its retention cutoff and then runs the three eviction passes, so up to
// WINDOW_DEPTH+1 entries can be evicted by one request. The insertion itself
// acts on the whole chain at once; eviction shifts the chain
// toward the head one entry per cycle. The result waits in its own register, so
// the next request is taken as soon as the sequencer is back in idle; while an
// earlier result is still stalled there, the sequencer holds in its last state.
// Configuration writes belong in idle periods.
module sliding_event_window_store #(
  parameter int WINDOW_DEPTH      = sews_pkg::DEF_WINDOW_DEPTH,
  parameter int FIXED_VALUE_BYTES = sews_pkg::DEF_FIXED_VALUE_BYTES
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_we,
  input  wire [sews_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [sews_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire [63:0]                     in_event_time,
  input  wire [31:0]                     in_event_tag,
  input  wire [15:0]                     in_name_length,
  input  wire                            in_value_is_text,
  input  wire [15:0]                     in_text_length,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [1:0]                     out_status,
  output logic                           out_stored,
  output logic [6:0]                     out_held_count,
  output logic [63:0]                    out_current_watermark,
  output logic [23:0]                    out_held_bytes,
  output logic [6:0]                     out_evicted_count
);

  localparam int CNT_W       = $clog2(WINDOW_DEPTH + 2);
  localparam int STORE_DEPTH = WINDOW_DEPTH + 1;

  sews_pkg::cell_cmd_t cell_cmd;
  sews_pkg::entry_t    entry_w [STORE_DEPTH];
  logic                gt_w    [STORE_DEPTH];
  logic [CNT_W-1:0]    total;

  sews_ctrl #(
    .WINDOW_DEPTH      (WINDOW_DEPTH),
    .FIXED_VALUE_BYTES (FIXED_VALUE_BYTES)
  ) u_ctrl (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_event_time         (in_event_time),
    .in_event_tag          (in_event_tag),
    .in_name_length        (in_name_length),
    .in_value_is_text      (in_value_is_text),
    .in_text_length        (in_text_length),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_stored            (out_stored),
    .out_held_count        (out_held_count),
    .out_current_watermark (out_current_watermark),
    .out_held_bytes        (out_held_bytes),
    .out_evicted_count     (out_evicted_count),
    .head_entry            (entry_w[0]),
    .cell_cmd              (cell_cmd),
    .total                 (total)
  );

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    sews_pkg::entry_t left_e;
    sews_pkg::entry_t right_e;
    logic             left_gt;

    if (i == 0) begin : g_head
      assign left_e  = '0;
      assign left_gt = 1'b0;
    end else begin : g_body
      assign left_e  = entry_w[i-1];
      assign left_gt = gt_w[i-1];
    end

    // The tail cell has no right neighbor; what it takes on a shift is never read.
    if (i == STORE_DEPTH - 1) begin : g_tail
      assign right_e = entry_w[i];
    end else begin : g_mid
      assign right_e = entry_w[i+1];
    end

    sews_cell #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .IDX          (i)
    ) u_cell (
      .clk         (clk),
      .total       (total),
      .cmd         (cell_cmd),
      .left_entry  (left_e),
      .left_gt     (left_gt),
      .right_entry (right_e),
      .entry       (entry_w[i]),
      .gt          (gt_w[i])
    );
  end

`ifndef SYNTHESIS
  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted but sequencer did not leave idle");

  a_stored_is_ok : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stored) |-> (out_status == sews_pkg::ST_OK))
    else $error("stored request reported with a non-ok status");

  a_reject_no_evict : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stored) |-> (out_evicted_count == 7'd0))
    else $error("unstored request reported evictions");

  a_total_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    (!in_stall) |-> (32'(total) <= 32'(WINDOW_DEPTH)))
    else $error("held count above window depth while idle");
`endif

endmodule
`default_nettype wire

/* tb/sv/sliding_event_window_store_test.sv */
// Self-checking testbench for the sliding event window store.
module sliding_event_window_store_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sews_pkg::*;

  localparam int          DEPTH          = DEF_WINDOW_DEPTH;
  localparam int          FIXED_BYTES    = DEF_FIXED_VALUE_BYTES;
  localparam int          HALF_PERIOD    = 6;
  localparam int          SETTLE_CYCLES  = DEPTH + 16;
  localparam int          HOLD_CYCLES    = 600;
  localparam int unsigned TIMEOUT_NS     = 12_000_000;
  localparam logic [1:0]  LATE_RESERVED  = 2'd3;
  localparam logic [63:0] TIME_MAX       = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [63:0] time_ms;
    logic [31:0] tag;
    logic [15:0] name_len;
    logic        is_text;
    logic [15:0] text_len;
  } event_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        stored;
    logic [6:0]  held;
    logic [63:0] mark;
    logic [23:0] bytes;
    logic [6:0]  evicted;
  } window_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [63:0] in_event_time = '0;
  logic [31:0] in_event_tag = '0;
  logic [15:0] in_name_length = '0;
  logic in_value_is_text = 1'b0;
  logic [15:0] in_text_length = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic out_stored;
  logic [6:0] out_held_count;
  logic [63:0] out_current_watermark;
  logic [23:0] out_held_bytes;
  logic [6:0] out_evicted_count;

  sliding_event_window_store dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_event_time(in_event_time),
    .in_event_tag(in_event_tag),
    .in_name_length(in_name_length),
    .in_value_is_text(in_value_is_text),
    .in_text_length(in_text_length),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_stored(out_stored),
    .out_held_count(out_held_count),
    .out_current_watermark(out_current_watermark),
    .out_held_bytes(out_held_bytes),
    .out_evicted_count(out_evicted_count)
  );

  // Predicted window contents, oldest entry at index zero.
  logic [63:0] win_time [0:DEPTH];
  logic [31:0] win_tag [0:DEPTH];
  logic [16:0] win_cost [0:DEPTH];
  int unsigned win_count = 0;
  logic [63:0] mark = '0;
  logic [23:0] bytes_held = '0;

  logic [31:0] keep_ms = 32'd1000;
  logic [6:0] count_cap = 7'd64;
  logic [23:0] byte_cap = 24'hFF_FFFF;
  logic [31:0] late_slack = '0;
  logic [1:0] late_mode = LATE_DROP;

  event_req_t pending_events[$];
  window_result_t expected_results[$];
  event_req_t cur_req;
  logic [63:0] gen_mark = '0;

  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit rush_input = 1'b0;
  bit hold_request = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_left = 0;
  int unsigned fail_count = 0;

  function automatic void shed_oldest();
    int unsigned i;
    bytes_held = bytes_held - 24'(win_cost[0]);
    for (i = 1; i < win_count; i++) begin
      win_time[i-1] = win_time[i];
      win_tag[i-1]  = win_tag[i];
      win_cost[i-1] = win_cost[i];
    end
    win_count--;
  endfunction

  function automatic window_result_t apply_event(event_req_t req);
    window_result_t r;
    int unsigned pos;
    int unsigned cap;
    int unsigned shed;
    logic [16:0] cost;
    logic [63:0] cutoff;
    r = '0;
    shed = 0;
    if (req.name_len == 16'd0) begin
      r.status = ST_INVALID;
    end else if (req.time_ms < mark && (mark - req.time_ms) > {32'd0, late_slack}) begin
      r.status = (late_mode == LATE_DROP)  ? ST_LATE_DROP :
                 (late_mode == LATE_ERROR) ? ST_LATE_ERROR : ST_OK;
    end else begin
      cost = {1'b0, req.name_len} + (req.is_text ? {1'b0, req.text_len} : 17'(FIXED_BYTES));
      pos = (win_count > DEPTH) ? DEPTH : win_count;
      // Later arrivals with an equal timestamp go behind the existing ones.
      while (pos != 0 && win_time[pos-1] > req.time_ms) begin
        win_time[pos] = win_time[pos-1];
        win_tag[pos]  = win_tag[pos-1];
        win_cost[pos] = win_cost[pos-1];
        pos--;
      end
      win_time[pos] = req.time_ms;
      win_tag[pos]  = req.tag;
      win_cost[pos] = cost;
      win_count = (win_count >= DEPTH) ? DEPTH + 1 : win_count + 1;
      bytes_held = bytes_held + 24'(cost);
      r.stored = 1'b1;
      if (req.time_ms > mark) mark = req.time_ms;
      cutoff = (mark > {32'd0, keep_ms}) ? mark - {32'd0, keep_ms} : '0;
      while (win_count != 0 && win_time[0] < cutoff) begin
        shed_oldest();
        shed++;
      end
      cap = (count_cap > DEPTH) ? DEPTH : count_cap;
      while (win_count > cap) begin
        shed_oldest();
        shed++;
      end
      while (win_count != 0 && bytes_held > byte_cap) begin
        shed_oldest();
        shed++;
      end
    end
    r.held    = 7'(win_count);
    r.mark    = mark;
    r.bytes   = bytes_held;
    r.evicted = 7'(shed);
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    fail_count++;
    if (fail_count <= 100)
      $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report(what, got, want);
  endtask

  initial begin
    forever #(HALF_PERIOD) clk = ~clk;
  end

  // Accepted requests and results are both taken at the rising edge. Results are
  // matched before a new request is predicted so they can never pair up wrongly.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      out_taken = 1'b1;
      if (expected_results.size() == 0) begin
        report("result with no request pending", out_current_watermark, '0);
      end else begin
        window_result_t want;
        want = expected_results.pop_front();
        check_field("status", out_status, want.status);
        check_field("stored", out_stored, want.stored);
        check_field("held_count", out_held_count, want.held);
        check_field("current_watermark", out_current_watermark, want.mark);
        check_field("held_bytes", out_held_bytes, want.bytes);
        check_field("evicted_count", out_evicted_count, want.evicted);
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(apply_event(cur_req));
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_taken) begin
        in_taken = 1'b0;
        if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
        tx_gap = (tx_quiet || rush_input) ? 0 : $urandom_range(0, 10);
      end
      if (tx_gap != 0 || pending_events.size() == 0) begin
        if (tx_gap != 0) tx_gap--;
        in_valid <= 1'b0;
      end else begin
        cur_req = pending_events.pop_front();
        in_valid         <= 1'b1;
        in_event_time    <= cur_req.time_ms;
        in_event_tag     <= cur_req.tag;
        in_name_length   <= cur_req.name_len;
        in_value_is_text <= cur_req.is_text;
        in_text_length   <= cur_req.text_len;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (out_taken) begin
      out_taken = 1'b0;
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      rx_wait = rx_quiet ? 0 : $urandom_range(0, 10);
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_wait != 0) begin
      rx_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_RETENTION_TIME:   keep_ms    = data;
      REG_MAX_EVENT_COUNT:  count_cap  = data[6:0];
      REG_MAX_TOTAL_BYTES:  byte_cap   = data[23:0];
      REG_ALLOWED_LATENESS: late_slack = data;
      REG_LATE_POLICY:      late_mode  = data[1:0];
      default: ;
    endcase
  endtask

  task automatic write_config(logic [31:0] retention, logic [6:0] count_limit,
                              logic [23:0] byte_limit, logic [31:0] slack,
                              logic [1:0] policy);
    write_reg(REG_RETENTION_TIME, retention);
    write_reg(REG_MAX_EVENT_COUNT, {25'd0, count_limit});
    write_reg(REG_MAX_TOTAL_BYTES, {8'd0, byte_limit});
    write_reg(REG_ALLOWED_LATENESS, slack);
    write_reg(REG_LATE_POLICY, {30'd0, policy});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The generator follows the watermark so that most requests land in order.
  task automatic queue_event(event_req_t req);
    if (req.name_len != 16'd0 && req.time_ms > gen_mark) gen_mark = req.time_ms;
    pending_events.push_back(req);
  endtask

  task automatic queue_fields(logic [63:0] t, logic [31:0] tag, logic [15:0] name_len,
                              logic is_text, logic [15:0] text_len);
    event_req_t req;
    req = '{time_ms: t, tag: tag, name_len: name_len, is_text: is_text, text_len: text_len};
    queue_event(req);
  endtask

  function automatic event_req_t make_event(int unsigned step, int unsigned back,
                                            bit wide_time);
    event_req_t req;
    int unsigned pick;
    int unsigned back_by;
    pick = $urandom_range(0, 99);
    req.tag = $urandom;
    req.is_text = 1'($urandom_range(0, 1));
    if (pick < 4) req.name_len = 16'd0;
    else if ($urandom_range(0, 9) == 0) req.name_len = 16'($urandom);
    else req.name_len = 16'($urandom_range(1, 300));
    req.text_len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
    if (wide_time && $urandom_range(0, 2) != 0) begin
      req.time_ms = {$urandom, $urandom};
    end else if (pick >= 80) begin
      back_by = $urandom_range(0, back);
      req.time_ms = (gen_mark > back_by) ? gen_mark - back_by : '0;
    end else begin
      req.time_ms = gen_mark + $urandom_range(0, step);
    end
    return req;
  endfunction

  task automatic run_random(int n, int unsigned step, int unsigned back, bit wide_time);
    repeat (n) queue_event(make_event(step, back, wide_time));
    wait_idle();
  endtask

  initial begin
    int p;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests under the reset configuration.
    queue_fields(64'd10, 32'd0, 16'd0, 1'b0, 16'd0);
    queue_fields(64'd0, 32'hFFFF_FFFF, 16'd1, 1'b0, 16'hFFFF);
    queue_fields(64'd100, 32'd1, 16'hFFFF, 1'b1, 16'hFFFF);
    queue_fields(64'd100, 32'd2, 16'd5, 1'b1, 16'd0);
    queue_fields(64'd50, 32'd3, 16'd8, 1'b0, 16'd0);
    queue_fields(64'd99, 32'd4, 16'd8, 1'b0, 16'd0);
    queue_fields(64'd100, 32'd5, 16'd1, 1'b1, 16'd1);
    queue_fields(64'd60, 32'd6, 16'd0, 1'b1, 16'd3);
    queue_fields(64'd1100, 32'd7, 16'd20, 1'b1, 16'd40);
    queue_fields(64'd1101, 32'd8, 16'd3, 1'b0, 16'd0);
    queue_fields(64'd1101, 32'd9, 16'd3, 1'b1, 16'd9);
    queue_fields(64'd3000, 32'd10, 16'd7, 1'b0, 16'd0);
    wait_idle();

    write_config(32'd3000, 7'd64, 24'hFF_FFFF, 32'd0, LATE_DROP);
    run_random(120, 50, 100, 1'b0);
    write_config(32'd500, 7'd16, 24'd4000, 32'd40, LATE_ERROR);
    run_random(100, 30, 80, 1'b0);
    // Zero retention keeps only entries at the watermark.
    write_config(32'd0, 7'd64, 24'hFF_FFFF, 32'd100, LATE_ACCEPT);
    run_random(60, 10, 20, 1'b0);
    write_config(32'hFFFF_FFFF, 7'd127, 24'd3000, 32'hFFFF_FFFF, LATE_RESERVED);
    run_random(100, 20, 200, 1'b0);
    write_config(32'd1, 7'd0, 24'hFF_FFFF, 32'd0, LATE_DROP);
    run_random(40, 5, 10, 1'b0);

    // Fill the window while the result side holds off, so the input backs up.
    write_config(32'hFFFF_FFFF, 7'd64, 24'hFF_FFFF, 32'hFFFF_FFFF, LATE_ACCEPT);
    rush_input = 1'b1;
    hold_request = 1'b1;
    run_random(80, 3, 0, 1'b0);
    rush_input = 1'b0;

    // A zero byte budget empties the full window in one request.
    write_config(32'hFFFF_FFFF, 7'd64, 24'd0, 32'hFFFF_FFFF, LATE_ACCEPT);
    run_random(6, 3, 0, 1'b0);

    for (p = 0; p < 5; p++) begin
      write_config($urandom_range(1, 10000), 7'($urandom_range(1, 64)),
                   24'($urandom_range(500, 20000)), $urandom_range(0, 200),
                   2'($urandom_range(0, 3)));
      run_random(100, $urandom_range(1, 100), $urandom_range(0, 300), 1'b0);
    end

    // Full-range timestamps last, since they push the watermark near the top.
    write_config($urandom, 7'd64, 24'hFF_FFFF, $urandom, 2'($urandom_range(0, 3)));
    repeat (100) queue_event(make_event(1000, 1000, 1'b1));
    queue_fields(TIME_MAX, 32'd11, 16'd4, 1'b0, 16'd0);
    queue_fields(TIME_MAX, 32'd12, 16'd4, 1'b1, 16'd4);
    queue_fields(64'd0, 32'd13, 16'd4, 1'b0, 16'd0);
    wait_idle();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/core/sews_pkg.sv
rtl/core/sews_cell.sv
rtl/core/sews_ctrl.sv
rtl/core/sliding_event_window_store.sv
tb/sv/sliding_event_window_store_test.sv
